// File: sv/wsc_pkg.sv
// wsc_pkg: shared types, constants and codes for the weighted sample compositor.
// No dependencies; used by wsc_ctrl, wsc_datapath and weighted_sample_compositor_core.
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;

	// Q1.15 channel and Q5.15 accumulator formats
	localparam int unsigned Q_W      = 16;
	localparam int unsigned ACC_W    = 20;
	localparam int unsigned MODE_W   = 3;
	localparam logic [Q_W-1:0]   ONE_Q15  = 16'h8000;
	localparam logic [Q_W-1:0]   HALF_Q15 = 16'h4000;
	localparam logic [ACC_W-1:0] ACC_MAX  = '1;

	// lanes: three colors plus alpha
	localparam int unsigned NUM_COLORS = 3;
	localparam int unsigned NUM_LANES  = 4;
	localparam int unsigned LANE_R     = 0;
	localparam int unsigned LANE_G     = 1;
	localparam int unsigned LANE_B     = 2;
	localparam int unsigned LANE_A     = 3;

	// final divide: one quotient bit per cycle
	localparam int unsigned DIV_STEPS = Q_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam int unsigned MAX_SAMPLES_DEF = 16;

	typedef enum logic [MODE_W-1:0] {
		BM_OVER_TOP    = 3'd0,
		BM_OVER_BOTTOM = 3'd1,
		BM_ADD         = 3'd2,
		BM_MAX         = 3'd3,
		BM_MIN         = 3'd4
	} blend_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREM,
		ST_BLEND,
		ST_DIV_INIT,
		ST_DIV,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load_in;
		logic prem;
		logic blend;
		logic first;
		logic div_init;
		logic div_step;
		logic out_load;
		logic cfg_we;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/wsc_datapath.sv
// wsc_datapath: alpha/premultiply lanes, blend accumulators and the bit-serial divider.
// Depends on wsc_pkg; driven by commands from wsc_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module wsc_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wsc_pkg::dp_cmd_t             cmd,
	output wsc_pkg::dp_stat_t                 stat,
	input  wire logic [wsc_pkg::MODE_W-1:0]   cfg_data,
	input  wire logic [wsc_pkg::Q_W-1:0]      sample_red,
	input  wire logic [wsc_pkg::Q_W-1:0]      sample_green,
	input  wire logic [wsc_pkg::Q_W-1:0]      sample_blue,
	input  wire logic [wsc_pkg::Q_W-1:0]      sample_alpha,
	input  wire logic [wsc_pkg::Q_W-1:0]      sample_weight,
	input  wire logic                         last_sample,
	output logic [wsc_pkg::Q_W-1:0]           out_red,
	output logic [wsc_pkg::Q_W-1:0]           out_green,
	output logic [wsc_pkg::Q_W-1:0]           out_blue,
	output logic [wsc_pkg::Q_W-1:0]           out_alpha
);

	localparam int unsigned QW = wsc_pkg::Q_W;
	localparam int unsigned AW = wsc_pkg::ACC_W;
	localparam int unsigned NC = wsc_pkg::NUM_COLORS;
	localparam int unsigned NL = wsc_pkg::NUM_LANES;

	function automatic logic [AW-1:0] sat_acc(input logic [AW+1:0] v);
		return (v > (AW+2)'(wsc_pkg::ACC_MAX)) ? wsc_pkg::ACC_MAX : v[AW-1:0];
	endfunction

	localparam int unsigned MODE_W_L = wsc_pkg::MODE_W;
	logic [MODE_W_L-1:0] mode_q;
	logic                     last_q;
	logic [NC-1:0][QW-1:0]    col_s1;
	logic [QW-1:0]            pa_s1;
	logic [NL-1:0][QW-1:0]    src_s2;
	logic [NL-1:0][AW-1:0]    acc_q;
	logic [QW-1:0]            ca_q;
	logic                     zero_q;
	logic [NC-1:0]            sat_q;
	logic [NC-1:0][QW-1:0]    rem_q;
	logic [NC-1:0][QW-1:0]    quo_q;
	logic [NC-1:0][QW-1:0]    shf_q;
	logic [QW-1:0]            out_red_q, out_green_q, out_blue_q, out_alpha_q;

	// stage 1: effective alpha straight from the ports
	logic [2*QW-1:0] aw_prod;
	logic [2*QW:0]   aw_rnd;
	logic [QW+1:0]   aw_val;
	logic [QW-1:0]   pa_in;

	always_comb begin
		aw_prod = sample_alpha * sample_weight;
		aw_rnd  = {1'b0, aw_prod} + (2*QW+1)'(wsc_pkg::HALF_Q15);
		aw_val  = aw_rnd[2*QW:QW-1];
		pa_in   = (aw_val > (QW+2)'(wsc_pkg::ONE_Q15)) ? wsc_pkg::ONE_Q15 : aw_val[QW-1:0];
	end

	// stage 2: premultiply colors
	logic [NC-1:0][2*QW-1:0] pm_prod;
	logic [NC-1:0][2*QW:0]   pm_rnd;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			pm_prod[c] = col_s1[c] * pa_s1;
			pm_rnd[c]  = {1'b0, pm_prod[c]} + (2*QW+1)'(wsc_pkg::HALF_Q15);
		end
	end

	// stage 3: fold into accumulators
	logic [QW-1:0]            ca_acc;
	logic [QW-1:0]            f_top, f_bot, mul_f;
	logic                     is_bot;
	logic [NL-1:0][AW-1:0]    mul_a, addend;
	logic [NL-1:0][AW+QW-1:0] bl_prod;
	logic [NL-1:0][AW+QW:0]   bl_rnd;
	logic [NL-1:0][AW:0]      bl_q;
	logic [NL-1:0][AW+1:0]    o_sum, a_sum;
	logic [NL-1:0][AW-1:0]    src_ext, acc_nxt;

	always_comb begin
		ca_acc = (acc_q[wsc_pkg::LANE_A] > AW'(wsc_pkg::ONE_Q15)) ? wsc_pkg::ONE_Q15
			: acc_q[wsc_pkg::LANE_A][QW-1:0];
		f_top  = wsc_pkg::ONE_Q15 - src_s2[wsc_pkg::LANE_A];
		f_bot  = wsc_pkg::ONE_Q15 - ca_acc;
		is_bot = (mode_q == wsc_pkg::BM_OVER_BOTTOM);
		mul_f  = is_bot ? f_bot : f_top;
		for (int l = 0; l < NL; l++) begin
			src_ext[l] = AW'(src_s2[l]);
			mul_a[l]   = is_bot ? src_ext[l] : acc_q[l];
			addend[l]  = is_bot ? acc_q[l] : src_ext[l];
			bl_prod[l] = mul_a[l] * mul_f;
			bl_rnd[l]  = {1'b0, bl_prod[l]} + (AW+QW+1)'(wsc_pkg::HALF_Q15);
			bl_q[l]    = bl_rnd[l][AW+QW-1:QW-1];
			o_sum[l]   = (AW+2)'(addend[l]) + (AW+2)'(bl_q[l]);
			a_sum[l]   = (AW+2)'(acc_q[l]) + (AW+2)'(src_ext[l]);
			case (mode_q)
				wsc_pkg::BM_ADD: acc_nxt[l] = sat_acc(a_sum[l]);
				wsc_pkg::BM_MAX: acc_nxt[l] = (acc_q[l] > src_ext[l]) ? acc_q[l] : src_ext[l];
				wsc_pkg::BM_MIN: acc_nxt[l] = (acc_q[l] < src_ext[l]) ? acc_q[l] : src_ext[l];
				default:         acc_nxt[l] = sat_acc(o_sum[l]);
			endcase
			if (cmd.first) begin
				acc_nxt[l] = src_ext[l];
			end
		end
	end

	// divider step: restoring, one quotient bit per lane per cycle
	logic [NC-1:0][QW:0]   dv_t, dv_d;
	logic [NC-1:0]         dv_ge;
	logic [NC-1:0][QW-1:0] res;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			dv_t[c]  = {rem_q[c], shf_q[c][QW-1]};
			dv_ge[c] = (dv_t[c] >= {1'b0, ca_q});
			dv_d[c]  = dv_t[c] - {1'b0, ca_q};
			if (zero_q) begin
				res[c] = '0;
			end else if (sat_q[c]) begin
				res[c] = wsc_pkg::ONE_Q15;
			end else begin
				res[c] = quo_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wsc_pkg::BM_OVER_TOP;
			last_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (cmd.cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.load_in) begin
				last_q <= last_sample;
			end
			if (cmd.blend) begin
				acc_q <= acc_nxt;
			end else if (cmd.out_load) begin
				acc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			col_s1[wsc_pkg::LANE_R] <= sample_red;
			col_s1[wsc_pkg::LANE_G] <= sample_green;
			col_s1[wsc_pkg::LANE_B] <= sample_blue;
			pa_s1                   <= pa_in;
		end
		if (cmd.prem) begin
			for (int c = 0; c < NC; c++) begin
				src_s2[c] <= pm_rnd[c][2*QW-2:QW-1];
			end
			src_s2[wsc_pkg::LANE_A] <= pa_s1;
		end
		if (cmd.div_init) begin
			ca_q   <= ca_acc;
			zero_q <= (acc_q[wsc_pkg::LANE_A] == '0);
			for (int c = 0; c < NC; c++) begin
				sat_q[c] <= (acc_q[c] > AW'(ca_acc));
				rem_q[c] <= acc_q[c][QW:1];
				shf_q[c] <= {acc_q[c][0], (QW-1)'(0)};
				quo_q[c] <= '0;
			end
		end else if (cmd.div_step) begin
			for (int c = 0; c < NC; c++) begin
				rem_q[c] <= dv_ge[c] ? dv_d[c][QW-1:0] : dv_t[c][QW-1:0];
				quo_q[c] <= {quo_q[c][QW-2:0], dv_ge[c]};
				shf_q[c] <= {shf_q[c][QW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_red_q   <= res[wsc_pkg::LANE_R];
			out_green_q <= res[wsc_pkg::LANE_G];
			out_blue_q  <= res[wsc_pkg::LANE_B];
			out_alpha_q <= zero_q ? '0 : ca_q;
		end
	end

	assign stat.last = last_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_alpha = out_alpha_q;

endmodule
`default_nettype wire

// File: sv/wsc_ctrl.sv
// wsc_ctrl: sequencer for the compositor, run bookkeeping and output/input handshakes.
// Depends on wsc_pkg; drives wsc_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module wsc_ctrl #(
	parameter int unsigned MAX_SAMPLES = wsc_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	output wsc_pkg::dp_cmd_t       cmd,
	input  wire wsc_pkg::dp_stat_t stat
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SW    = wsc_pkg::STEP_W;

	wsc_pkg::ctl_state_t state_q, state_nxt;
	logic [CNT_W-1:0]    cnt_q;
	logic                first_q;
	logic [SW-1:0]       step_q;
	logic                out_valid_q;
	logic                out_free, run_end, last_step, accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign run_end   = stat.last || (cnt_q == CNT_W'(MAX_SAMPLES - 1));
	assign last_step = (step_q == SW'(wsc_pkg::DIV_STEPS - 1));
	assign accept    = in_valid && (state_q == wsc_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wsc_pkg::ST_IDLE:     if (accept) state_nxt = wsc_pkg::ST_PREM;
			wsc_pkg::ST_PREM:     state_nxt = wsc_pkg::ST_BLEND;
			wsc_pkg::ST_BLEND:    state_nxt = run_end ? wsc_pkg::ST_DIV_INIT : wsc_pkg::ST_IDLE;
			wsc_pkg::ST_DIV_INIT: state_nxt = wsc_pkg::ST_DIV;
			wsc_pkg::ST_DIV:      if (last_step) state_nxt = wsc_pkg::ST_DONE;
			wsc_pkg::ST_DONE:     if (out_free) state_nxt = wsc_pkg::ST_IDLE;
			default:              state_nxt = wsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.cfg_we   = cfg_valid;
		cmd.first    = first_q;
		in_stall     = 1'b1;
		case (state_q)
			wsc_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			wsc_pkg::ST_PREM:     cmd.prem = 1'b1;
			wsc_pkg::ST_BLEND:    cmd.blend = 1'b1;
			wsc_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
			wsc_pkg::ST_DIV:      cmd.div_step = 1'b1;
			wsc_pkg::ST_DONE:     cmd.out_load = out_free;
			default:              cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsc_pkg::ST_IDLE;
			cnt_q       <= '0;
			first_q     <= 1'b1;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wsc_pkg::ST_BLEND) begin
				first_q <= run_end;
				cnt_q   <= run_end ? '0 : cnt_q + CNT_W'(1);
			end
			if (state_q == wsc_pkg::ST_DIV_INIT) begin
				step_q <= '0;
			end else if (state_q == wsc_pkg::ST_DIV) begin
				step_q <= step_q + SW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: sv/weighted_sample_compositor_core.sv
// weighted_sample_compositor_core: top level, wsc_ctrl sequencer plus wsc_datapath.
// A sample that does not end a run passes through alpha multiply, premultiply and blend.
// A run-ending sample adds a divider setup step, 16 bit-serial divide steps and an output
// load that raises out_valid; the load, and with it the next sample, waits while the
// previous pixel still sits unread at the output.
// arst_n clears the sequencer, accumulators, run count and blend mode (new on top).
`timescale 1ns / 1ps
`default_nettype none
module weighted_sample_compositor_core #(
	parameter int unsigned MAX_SAMPLES = wsc_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// sample input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [wsc_pkg::Q_W-1:0]    sample_red,
	input  wire logic [wsc_pkg::Q_W-1:0]    sample_green,
	input  wire logic [wsc_pkg::Q_W-1:0]    sample_blue,
	input  wire logic [wsc_pkg::Q_W-1:0]    sample_alpha,
	input  wire logic [wsc_pkg::Q_W-1:0]    sample_weight,
	input  wire logic                       last_sample,
	// pixel output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [wsc_pkg::Q_W-1:0]         out_red,
	output logic [wsc_pkg::Q_W-1:0]         out_green,
	output logic [wsc_pkg::Q_W-1:0]         out_blue,
	output logic [wsc_pkg::Q_W-1:0]         out_alpha,
	// blend mode register write
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [wsc_pkg::MODE_W-1:0] cfg_data
);

	// Sequencer and datapath talk only through these two structs.
	// An input item is taken only in idle; a finished pixel sits in the output
	// register so the next run can start while the consumer stalls. The last
	// stage waits only if a new result is ready and the previous one is unread.
	wsc_pkg::dp_cmd_t  dp_cmd;
	wsc_pkg::dp_stat_t dp_stat;

	wsc_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	// Datapath: four lanes (r, g, b, alpha), one multiplier each in the blend stage;
	// accumulators saturate at 20 bits; the divide is restoring, one bit a cycle.
	wsc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.cfg_data      (cfg_data),
		.sample_red    (sample_red),
		.sample_green  (sample_green),
		.sample_blue   (sample_blue),
		.sample_alpha  (sample_alpha),
		.sample_weight (sample_weight),
		.last_sample   (last_sample),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.out_alpha     (out_alpha)
	);

	// Only one datapath step is commanded in any cycle.
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.load_in, dp_cmd.prem, dp_cmd.blend, dp_cmd.div_init,
			dp_cmd.div_step, dp_cmd.out_load}))
		else $error("more than one datapath step in a cycle");

	// An accepted item is premultiplied next cycle, then blended the cycle after.
	a_accept_prem: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> dp_cmd.prem)
		else $error("accepted item not premultiplied");

	a_prem_blend: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.prem |=> dp_cmd.blend)
		else $error("premultiplied item not blended");

	// The output register is never overwritten while a result is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register overwritten");

	// Composited alpha is clamped to 1.0.
	a_alpha_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_alpha <= wsc_pkg::ONE_Q15))
		else $error("output alpha above 1.0");

endmodule
`default_nettype wire

// File: verif/tb_weighted_sample_compositor_core.sv
// Self-checking testbench for weighted_sample_compositor_core: a scoreboard class predicts
// each composited pixel from the accepted samples and the current blend mode.
// Depends on wsc_pkg (widths, Q1.15 constants, blend mode codes) and the core RTL.
`timescale 1ns / 1ps
module tb_weighted_sample_compositor_core;
	import wsc_pkg::*;

	localparam int unsigned RUN_LIMIT   = 16;     // samples per run before a forced end
	localparam int          NUM_ITEMS   = 1450;   // random samples after the directed part
	localparam int          HOLD_CYCLES = 300;    // long output hold-off for back pressure
	localparam int          IDLE_LIMIT  = 4000;   // watchdog: cycles with no item moving
	localparam int          SETTLE      = 30;     // settle time, longer than a run-ending sample takes
	localparam logic [MODE_W-1:0] MODE_TOP_CODE = 3'd7;   // undefined code, acts as on top
	localparam logic [Q_W-1:0]    Q_ALL_ONES    = 16'hFFFF;

	// Predicts one output pixel per run and holds the pixels still to come out.
	class pixel_scoreboard;
		typedef struct packed {
			logic [Q_W-1:0] red;
			logic [Q_W-1:0] green;
			logic [Q_W-1:0] blue;
			logic [Q_W-1:0] alpha;
		} pixel_t;

		pixel_t            pending_pixels[$];
		logic [MODE_W-1:0] mode;
		logic [ACC_W-1:0]  acc[NUM_LANES];
		bit                run_open;
		int                run_len;
		int                errors;

		function new();
			mode = BM_OVER_TOP;
			errors = 0;
			clear_run();
		endfunction

		function void clear_run();
			foreach (acc[i]) acc[i] = '0;
			run_open = 1'b0;
			run_len = 0;
		endfunction

		// Q1.15 product, round half up, saturated to the accumulator width
		function logic [ACC_W-1:0] qmul(logic [ACC_W-1:0] x, logic [ACC_W-1:0] f);
			logic [63:0] p;
			p = (64'(x) * 64'(f) + 64'(HALF_Q15)) >> 15;
			return (p > 64'(ACC_MAX)) ? ACC_MAX : p[ACC_W-1:0];
		endfunction

		function logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] x, logic [ACC_W-1:0] y);
			logic [ACC_W:0] s;
			s = {1'b0, x} + {1'b0, y};
			return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
		endfunction

		function logic [Q_W-1:0] unpremul(logic [ACC_W-1:0] c, logic [Q_W-1:0] a);
			logic [63:0] q;
			q = (64'(c) << 15) / 64'(a);
			return (q > 64'(ONE_Q15)) ? ONE_Q15 : q[Q_W-1:0];
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
		endfunction

		function void take_sample(logic [Q_W-1:0] r, logic [Q_W-1:0] g, logic [Q_W-1:0] b,
				logic [Q_W-1:0] a, logic [Q_W-1:0] w, logic last);
			logic [ACC_W-1:0] prem[NUM_LANES];
			logic [ACC_W-1:0] chan[NUM_COLORS];
			logic [ACC_W-1:0] f;
			logic [Q_W-1:0]   ca;
			pixel_t           px;
			chan[LANE_R] = r;
			chan[LANE_G] = g;
			chan[LANE_B] = b;
			prem[LANE_A] = qmul(a, w);
			if (prem[LANE_A] > ONE_Q15)
				prem[LANE_A] = ONE_Q15;
			for (int i = 0; i < NUM_COLORS; i++)
				prem[i] = qmul(chan[i], prem[LANE_A]);

			if (!run_open) begin
				foreach (acc[i]) acc[i] = prem[i];
			end else begin
				case (mode)
					BM_OVER_BOTTOM: begin
						f = ONE_Q15 - ((acc[LANE_A] > ONE_Q15) ? ONE_Q15 : acc[LANE_A]);
						foreach (acc[i]) acc[i] = sat_add(acc[i], qmul(prem[i], f));
					end
					BM_ADD: begin
						foreach (acc[i]) acc[i] = sat_add(acc[i], prem[i]);
					end
					BM_MAX: begin
						foreach (acc[i]) acc[i] = (prem[i] > acc[i]) ? prem[i] : acc[i];
					end
					BM_MIN: begin
						foreach (acc[i]) acc[i] = (prem[i] < acc[i]) ? prem[i] : acc[i];
					end
					default: begin
						f = ONE_Q15 - prem[LANE_A];
						foreach (acc[i]) acc[i] = sat_add(prem[i], qmul(acc[i], f));
					end
				endcase
			end
			run_open = 1'b1;
			run_len++;

			if (last || run_len >= RUN_LIMIT) begin
				if (acc[LANE_A] == '0) begin
					px = '0;
				end else begin
					ca = (acc[LANE_A] > ONE_Q15) ? ONE_Q15 : acc[LANE_A][Q_W-1:0];
					px.red   = unpremul(acc[LANE_R], ca);
					px.green = unpremul(acc[LANE_G], ca);
					px.blue  = unpremul(acc[LANE_B], ca);
					px.alpha = ca;
				end
				pending_pixels = {pending_pixels, px};
				clear_run();
			end
		endfunction

		function void check_pixel(logic [Q_W-1:0] r, logic [Q_W-1:0] g, logic [Q_W-1:0] b,
				logic [Q_W-1:0] a);
			pixel_t px;
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $realtime,
						r, g, b, a);
				return;
			end
			px = pending_pixels.pop_front();
			if (px.red !== r || px.green !== g || px.blue !== b || px.alpha !== a) begin
				errors++;
				if (errors <= 10)
					$display("%0t: pixel mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$realtime, px.red, px.green, px.blue, px.alpha, r, g, b, a);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [Q_W-1:0] sample_red, sample_green, sample_blue, sample_alpha, sample_weight;
	logic last_sample;
	logic out_valid;
	logic out_stall;
	logic [Q_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic cfg_valid;
	logic cfg_ready;
	logic [MODE_W-1:0] cfg_data;

	pixel_scoreboard sb;
	int items_sent;
	bit hold_req;     // driver asks the output side for one long hold-off

	weighted_sample_compositor_core #(
		.MAX_SAMPLES(RUN_LIMIT)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_red   (sample_red),
		.sample_green (sample_green),
		.sample_blue  (sample_blue),
		.sample_alpha (sample_alpha),
		.sample_weight(sample_weight),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Channel or alpha level: the extremes, plain Q1.15 values, and values above 1.0.
	function automatic logic [Q_W-1:0] rand_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return ONE_Q15;
			2:       return Q_ALL_ONES;
			3:       return $urandom;
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	// Weight leans toward 1.0 so most alphas carry through.
	function automatic logic [Q_W-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0, 1, 2: return ONE_Q15;
			3:       return '0;
			4:       return $urandom;
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	// Offer one sample and hold it until taken. With a zero gap in_valid stays high on return
	// so that the next call can drive the following item in the same step.
	task automatic send_sample(input logic [Q_W-1:0] r, input logic [Q_W-1:0] g,
			input logic [Q_W-1:0] b, input logic [Q_W-1:0] a, input logic [Q_W-1:0] w,
			input logic last, input int gap);
		in_valid      <= 1'b1;
		sample_red    <= r;
		sample_green  <= g;
		sample_blue   <= b;
		sample_alpha  <= a;
		sample_weight <= w;
		last_sample   <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_sample(r, g, b, a, w, last);
		items_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mode writes only on an idle block: all pixels out, plus time for a trailing
	// non-final sample to finish its blend.
	task automatic write_blend_mode(input logic [MODE_W-1:0] m);
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_mode(m);
		cfg_valid <= 1'b0;
	endtask

	// Result side: compare every accepted pixel against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(out_red, out_green, out_blue, out_alpha);
	end

	// Output stall pattern: random release/stall stretches, some long clean stretches,
	// and one long hold-off on request so the block fills and stalls its input.
	initial begin : receiver
		int stall_len;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(50, 150)) @(posedge clk);
				else
					repeat ($urandom_range(1, 12)) @(posedge clk);
				stall_len = idle_gap();
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: ends the run when no item moves on any channel for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("weighted_sample_compositor_core verification failed");
		$finish;
	end

	initial begin : driver
		int  kind;
		int  len;
		int  next_cfg;
		int  r;
		bit  tight;
		bit  hold_started;
		logic lst;

		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sample_red    = '0;
		sample_green  = '0;
		sample_blue   = '0;
		sample_alpha  = '0;
		sample_weight = '0;
		last_sample   = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		hold_req      = 1'b0;
		hold_started  = 1'b0;
		items_sent    = 0;
		sb = new();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// new on top: two-sample over, zero alpha alone, everything above 1.0
		write_blend_mode(BM_OVER_TOP);
		send_sample(ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample('0, HALF_Q15, ONE_Q15, HALF_Q15, ONE_Q15, 1'b1, idle_gap());
		send_sample(16'd1234, 16'd5678, 16'd9999, '0, ONE_Q15, 1'b1, idle_gap());
		send_sample(Q_ALL_ONES, Q_ALL_ONES, Q_ALL_ONES, Q_ALL_ONES, Q_ALL_ONES, 1'b1, 0);

		// new underneath: each layer only fills what the ones above left open
		write_blend_mode(BM_OVER_BOTTOM);
		send_sample(ONE_Q15, '0, '0, HALF_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample('0, ONE_Q15, '0, HALF_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample('0, '0, ONE_Q15, ONE_Q15, HALF_Q15, 1'b1, idle_gap());

		// add with oversized inputs, pushing the output clamp
		write_blend_mode(BM_ADD);
		send_sample(Q_ALL_ONES, ONE_Q15, 16'd1, Q_ALL_ONES, Q_ALL_ONES, 1'b0, idle_gap());
		send_sample(Q_ALL_ONES, ONE_Q15, 16'd1, Q_ALL_ONES, Q_ALL_ONES, 1'b1, idle_gap());

		write_blend_mode(BM_MAX);
		send_sample(16'd100, 16'd30000, ONE_Q15, HALF_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample(ONE_Q15, 16'd200, 16'd50, ONE_Q15, HALF_Q15, 1'b1, idle_gap());

		// minimum: zero weight drives the alpha to zero, so an all-zero pixel
		write_blend_mode(BM_MIN);
		send_sample(ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample(16'd10, 16'd20000, 16'd30, HALF_Q15, '0, 1'b1, idle_gap());

		// undefined mode code behaves as new on top
		write_blend_mode(MODE_TOP_CODE);
		send_sample(ONE_Q15, '0, HALF_Q15, HALF_Q15, ONE_Q15, 1'b0, idle_gap());
		send_sample('0, ONE_Q15, HALF_Q15, HALF_Q15, ONE_Q15, 1'b1, idle_gap());

		// mode switched in the middle of a run
		write_blend_mode(BM_MAX);
		send_sample(ONE_Q15, ONE_Q15, '0, HALF_Q15, ONE_Q15, 1'b0, idle_gap());
		write_blend_mode(BM_ADD);
		send_sample('0, HALF_Q15, ONE_Q15, 16'h2000, ONE_Q15, 1'b1, idle_gap());

		// ---- random part ----
		// Mostly well-formed runs; some reach or overrun the run limit with no last flag,
		// some are noise with random last flags. Mode changes land between items, which
		// is often inside a run.
		next_cfg = items_sent + $urandom_range(20, 60);
		while (items_sent < NUM_ITEMS + 17) begin
			if (items_sent >= next_cfg) begin
				r = $urandom_range(0, 9);
				write_blend_mode((r < 8) ? MODE_W'(r) : MODE_W'($urandom_range(0, 4)));
				next_cfg = items_sent + $urandom_range(40, 90);
			end
			if (!hold_started && items_sent >= 700) begin
				hold_started = 1'b1;
				hold_req = 1'b1;
			end
			kind  = $urandom_range(0, 99);
			tight = ($urandom_range(0, 4) == 0);
			if (kind < 80)
				len = $urandom_range(1, 6);
			else if (kind < 88)
				len = $urandom_range(7, RUN_LIMIT);
			else if (kind < 94)
				len = $urandom_range(RUN_LIMIT, RUN_LIMIT + 4);
			else
				len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				if (kind < 88)
					lst = (k == len - 1);
				else if (kind < 94)
					lst = 1'b0;
				else
					lst = $urandom_range(0, 1);
				send_sample(rand_level(), rand_level(), rand_level(), rand_level(),
					rand_weight(), lst, (tight || hold_req) ? 0 : idle_gap());
			end
		end
		in_valid <= 1'b0;

		// drain: every predicted pixel out, then watch a while for strays
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE + 10) @(posedge clk);

		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("weighted_sample_compositor_core verification clean");
		else
			$display("weighted_sample_compositor_core verification failed");
		$finish;
	end
endmodule

// File: sim.f
sv/wsc_pkg.sv
sv/wsc_datapath.sv
sv/wsc_ctrl.sv
sv/weighted_sample_compositor_core.sv
verif/tb_weighted_sample_compositor_core.sv
